// ===== sv/b2da_pkg.sv =====
// Package with shared types and constants of the binary to decimal ASCII unit.
package b2da_pkg;

    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned DIGIT_W    = 4;
    localparam int unsigned MAG_EXT_W  = VALUE_W + 1;
    localparam int unsigned NUM_PLACES = 5;
    localparam int unsigned PLACE_W    = $clog2(NUM_PLACES);
    localparam int unsigned MAX_DIGIT  = 9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [MAG_EXT_W-1:0] POW10 [NUM_PLACES] = '{
        17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic last_place;
    } t_stat;

endpackage

// ===== sv/b2da_dp.sv =====
// Datapath: magnitude register, decimal digit extraction and output register.
module b2da_dp
    import b2da_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  logic [VALUE_W-1:0]   i_value_bits,
    input  logic                 i_signed_mode,
    output t_stat                o_stat,
    output logic                 o_valid,
    output logic [CHAR_W-1:0]    o_text_char,
    output logic                 o_last_char
);

    logic [VALUE_W-1:0]   r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic [PLACE_W-1:0]   r_place, n_place;
    logic                 r_valid, n_valid;
    logic [CHAR_W-1:0]    r_char, n_char;
    logic                 r_last, n_last;

    logic                 load_neg;
    logic [VALUE_W-1:0]   load_mag;
    logic [PLACE_W-1:0]   load_place;
    logic [DIGIT_W-1:0]   digit;
    logic [MAG_EXT_W-1:0] sub_val;
    logic [MAG_EXT_W-1:0] mult;

    always_comb begin
        load_neg = i_signed_mode & i_value_bits[VALUE_W-1];
        load_mag = load_neg ? ((~i_value_bits) + 16'd1) : i_value_bits;
        load_place = '0;
        for (int p = 1; p < NUM_PLACES; p++) begin
            if ({1'b0, load_mag} >= POW10[p]) begin
                load_place = PLACE_W'(p);
            end
        end
    end

    always_comb begin
        digit   = '0;
        sub_val = '0;
        mult    = '0;
        for (int k = 1; k <= MAX_DIGIT; k++) begin
            mult = MAG_EXT_W'(POW10[r_place] * MAG_EXT_W'(k));
            if ({1'b0, r_mag} >= mult) begin
                digit   = DIGIT_W'(k);
                sub_val = mult;
            end
        end
    end

    always_comb begin
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_place = r_place;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        priority if (i_cmd.load) begin
            n_mag   = load_mag;
            n_neg   = load_neg;
            n_place = load_place;
        end else if (i_cmd.emit_sign) begin
            n_valid = 1'b1;
            n_char  = CHAR_MINUS;
            n_last  = 1'b0;
        end else if (i_cmd.emit_digit) begin
            n_valid = 1'b1;
            n_char  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digit};
            n_last  = (r_place == '0);
            n_mag   = VALUE_W'({1'b0, r_mag} - sub_val);
            if (r_place != '0) begin
                n_place = r_place - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_place <= n_place;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    assign o_stat.neg        = r_neg;
    assign o_stat.last_place = (r_place == '0);
    assign o_valid           = r_valid;
    assign o_text_char       = r_char;
    assign o_last_char       = r_last;

endmodule

// ===== sv/b2da_ctrl.sv =====
// Controller: state machine that sequences the sign and digit characters of one item.
module b2da_ctrl
    import b2da_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (i_stat.neg || !i_stat.last_place) begin
                    n_state = ST_DIGIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIGIT: begin
                if (i_stat.last_place) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            ST_SIGN: begin
                o_cmd.emit_sign  = i_stat.neg;
                o_cmd.emit_digit = !i_stat.neg;
            end
            ST_DIGIT: begin
                o_cmd.emit_digit = 1'b1;
            end
            default: o_busy = 1'b0;
        endcase
    end

endmodule

// ===== sv/binary_to_decimal_ascii_unit.sv =====
// Top level of the binary to decimal ASCII unit: controller, datapath and checks.
// An item is taken when i_start is high while o_busy is low. The unit then prints the
// value as decimal text, one character per cycle, most significant first: a leading '-'
// for a negative signed value, then the digits without leading zeros, the last one
// flagged by o_last_char. Each character is on the outputs for exactly one cycle with
// o_valid high, and the receiver cannot stall it. An item keeps o_busy high while its
// characters are issued from ST_SIGN and, for further characters, ST_DIGIT, the digit unit
// resolving one decimal place per cycle; the next item can be taken as soon as o_busy is
// low again, which is in the cycle that shows the last character. At the accepting edge
// the item is loaded; the first character is issued from ST_SIGN and then registered.
module binary_to_decimal_ascii_unit
    import b2da_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [VALUE_W-1:0]  i_value_bits,
    input  logic                i_signed_mode,
    output logic                o_busy,
    output logic                o_valid,
    output logic [CHAR_W-1:0]   o_text_char,
    output logic                o_last_char
);

    t_cmd  cmd;
    t_stat stat;

    b2da_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    b2da_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value_bits  (i_value_bits),
        .i_signed_mode (i_signed_mode),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char)
    );

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |=> !o_valid)
        else $error("A character followed the last character without a new item.");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_text_char == CHAR_MINUS)) |-> !o_last_char)
        else $error("A minus sign was flagged as the last character.");

    a_no_char_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> !o_valid)
        else $error("A character appeared right after an item was accepted.");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_text_char == CHAR_MINUS) ||
                     ((o_text_char >= CHAR_ZERO) && (o_text_char <= CHAR_NINE))))
        else $error("An output character is neither a digit nor a minus sign.");

endmodule

// ===== bench/binary_to_decimal_ascii_unit_tb.sv =====
// Self-checking bench for the binary to decimal ASCII unit: directed table, then random values.
module binary_to_decimal_ascii_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import b2da_pkg::*;

    localparam int RANDOM_ITEMS = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_SHOWN    = 10;
    localparam int MAX_GAP      = 18;
    localparam int NUM_DIRECTED = 21;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               sgn;
        string              text;
    } t_directed_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic [VALUE_W-1:0] i_value_bits;
    logic               i_signed_mode;
    logic               o_busy;
    logic               o_valid;
    logic [CHAR_W-1:0]  o_text_char;
    logic               o_last_char;

    t_text_char pending_chars[$];
    int         mismatches = 0;
    int         cycles = 0;

    // An empty text means the expected characters come from the predictor.
    t_directed_row directed_rows [NUM_DIRECTED] = '{
        '{16'h0000, 1'b0, "0"},
        '{16'h0000, 1'b1, "0"},
        '{16'hFFFF, 1'b0, "65535"},
        '{16'hFFFF, 1'b1, "-1"},
        '{16'h8000, 1'b1, "-32768"},
        '{16'h8000, 1'b0, "32768"},
        '{16'h7FFF, 1'b1, "32767"},
        '{16'h8001, 1'b1, "-32767"},
        '{16'h0001, 1'b0, "1"},
        '{16'h0009, 1'b1, "9"},
        '{16'h000A, 1'b0, "10"},
        '{16'h0064, 1'b1, "100"},
        '{16'h03E8, 1'b0, "1000"},
        '{16'h270F, 1'b0, "9999"},
        '{16'h2710, 1'b1, "10000"},
        '{16'hFFF6, 1'b1, "-10"},
        '{16'hD8F0, 1'b1, "-10000"},
        '{16'h5555, 1'b0, ""},
        '{16'h5555, 1'b1, ""},
        '{16'hAAAA, 1'b0, ""},
        '{16'hAAAA, 1'b1, ""}
    };

    binary_to_decimal_ascii_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_value_bits  (i_value_bits),
        .i_signed_mode (i_signed_mode),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_text_char   (o_text_char),
        .o_last_char   (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void queue_decimal_text(input logic [VALUE_W-1:0] raw, input logic sgn);
        logic             neg;
        logic [MAG_EXT_W-1:0] mag;
        logic [DIGIT_W-1:0] digits [NUM_PLACES];
        int               count;
        neg   = sgn & raw[VALUE_W-1];
        mag   = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        count = 0;
        if (mag == '0) begin
            digits[0] = '0;
            count = 1;
        end else begin
            while (mag != '0 && count < NUM_PLACES) begin
                digits[count] = DIGIT_W'(mag % 10);
                mag = MAG_EXT_W'(mag / 10);
                count++;
            end
        end
        if (neg) pending_chars.push_back('{CHAR_MINUS, 1'b0});
        for (int k = count - 1; k >= 0; k--) begin
            pending_chars.push_back('{CHAR_ZERO + CHAR_W'(digits[k]), (k == 0)});
        end
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) $display("mismatch: %s", msg);
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] value, input logic sgn, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start       <= 1'b1;
        i_value_bits  <= value;
        i_signed_mode <= sgn;
        do @(posedge i_clk); while (o_busy !== 1'b0);
    endtask

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (pending_chars.size() == 0) begin
                flag_mismatch($sformatf("unexpected char %h last %b valid %b",
                                        o_text_char, o_last_char, o_valid));
            end else begin
                want = pending_chars.pop_front();
                if (o_valid !== 1'b1 || o_text_char !== want.ch || o_last_char !== want.last) begin
                    flag_mismatch($sformatf("char exp %h last %b, got %h last %b valid %b",
                                            want.ch, want.last, o_text_char, o_last_char,
                                            o_valid));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [VALUE_W-1:0] value;
        logic               sgn;
        int                 gap;
        string              text;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_value_bits  = '0;
        i_signed_mode = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_value(directed_rows[r].value, directed_rows[r].sgn, $urandom_range(0, 3));
            text = directed_rows[r].text;
            if (text.len() == 0) begin
                queue_decimal_text(directed_rows[r].value, directed_rows[r].sgn);
            end else begin
                for (int k = 0; k < text.len(); k++) begin
                    pending_chars.push_back('{CHAR_W'(text[k]), (k == text.len() - 1)});
                end
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sgn = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: value = VALUE_W'($urandom_range(0, 65535));
                1: value = VALUE_W'($urandom_range(0, 99));
                2: value = VALUE_W'(POW10[$urandom_range(0, NUM_PLACES - 1)]
                                    + $urandom_range(0, 2) - 1);
                default: value = 16'h8000 | VALUE_W'($urandom_range(0, 15));
            endcase
            if (sgn && $urandom_range(0, 1) == 1) value = -value;
            gap = ((n % 60) < 20) ? 0 : $urandom_range(0, MAX_GAP);
            send_value(value, sgn, gap);
            queue_decimal_text(value, sgn);
        end

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_chars.size() != 0) begin
            flag_mismatch($sformatf("%0d chars never arrived", pending_chars.size()));
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
